// File: sv/dfe_pkg.sv
// ----------------------------------------------------------------------------
// Delimited frame extractor package
// Shared types, status codes and defaults for the frame extractor.
// ----------------------------------------------------------------------------
package dfe_pkg;

  localparam int DEF_BUFFER_BYTES     = 4096;
  localparam int DEF_MAX_MARKER_BYTES = 8;
  localparam int DEF_MAX_FRAME_BYTES  = 512;

  localparam logic [2:0] STS_STORED  = 3'd0;
  localparam logic [2:0] STS_DROPPED = 3'd1;
  localparam logic [2:0] STS_FRAME   = 3'd2;
  localparam logic [2:0] STS_NOFRAME = 3'd3;
  localparam logic [2:0] STS_JUNK    = 3'd4;

  localparam logic [1:0] REG_START_MARKER     = 2'd0;
  localparam logic [1:0] REG_START_MARKER_LEN = 2'd1;
  localparam logic [1:0] REG_STOP_MARKER      = 2'd2;
  localparam logic [1:0] REG_STOP_MARKER_LEN  = 2'd3;

  localparam logic ACT_PUSH    = 1'b0;
  localparam logic ACT_EXTRACT = 1'b1;

  typedef struct packed {
    logic        action;
    logic [7:0]  data_byte;
    logic        first_of_chunk;
    logic [12:0] chunk_length;
    logic [9:0]  max_length;
  } in_item_t;

  typedef struct packed {
    logic [2:0]  status;
    logic [63:0] frame_word;
    logic [3:0]  word_bytes;
    logic [9:0]  frame_length;
    logic        last;
  } out_item_t;

  typedef struct packed {
    logic start_hit;
    logic stop_hit;
  } match_t;

  // Mask covering the first len bytes of a marker, len in 1..8.
  function automatic logic [63:0] byte_mask(input logic [3:0] len);
    byte_mask = ~64'd0 >> (7'd64 - {len, 3'b000});
  endfunction

endpackage

// File: sv/delimited_frame_extractor.sv
// ----------------------------------------------------------------------------
// Delimited frame extractor
// Ring buffer of pushed bytes with a byte-serial marker search and frame read.
// ----------------------------------------------------------------------------
// Usage: the input channel (in_valid/in_ready/in_data) carries one transaction
// per pushed byte or extract request. Every transaction produces one or more
// result transactions on out_valid/out_ready/out_data, the final one flagged
// by last. A push result is registered at the accepting edge and offered in
// the next cycle, so pushes can follow one per cycle while the receiver keeps
// out_ready high. An extract reads the buffer through a single memory read
// port, one byte at a time: the search walks the unread bytes from the read
// point until both markers have been seen or the unread bytes run out, a
// decision state follows, then the frame is read back byte by byte and
// offered in 8-byte words. The block takes one transaction at a time and
// holds in_ready low throughout an extract. A stalled receiver simply holds
// the sequencer at the next result; nothing is lost. Reset empties the
// buffer (read point and unread count to zero) and restores the marker
// registers to their defaults; the byte store itself is not cleared.
// Configuration writes go through cfg_we/cfg_index/cfg_wdata.
// ----------------------------------------------------------------------------
module delimited_frame_extractor #(
  parameter int BUFFER_BYTES     = dfe_pkg::DEF_BUFFER_BYTES,
  parameter int MAX_MARKER_BYTES = dfe_pkg::DEF_MAX_MARKER_BYTES,
  parameter int MAX_FRAME_BYTES  = dfe_pkg::DEF_MAX_FRAME_BYTES
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_ready,
  input  dfe_pkg::in_item_t   in_data,
  output logic                out_valid,
  input  logic                out_ready,
  output dfe_pkg::out_item_t  out_data,
  input  logic                cfg_we,
  input  logic [1:0]          cfg_index,
  input  logic [63:0]         cfg_wdata
);

  localparam int AW = $clog2(BUFFER_BYTES);
  localparam int CW = AW + 1;
  localparam int SW = ((CW > 13) ? CW : 13) + 1;

  typedef enum logic [2:0] {
    S_IDLE, S_SCAN_RD, S_SCAN_CMP, S_DECIDE, S_FR_RD, S_FR_CMP, S_EMIT
  } state_t;

  // Address arithmetic modulo the buffer size, which need not be a power of two.
  function automatic logic [AW-1:0] wrap_add(input logic [AW-1:0] a,
                                             input logic [AW-1:0] b);
    logic [AW:0] sum;
    sum = {1'b0, a} + {1'b0, b};
    if (sum >= (AW+1)'(BUFFER_BYTES)) begin
      sum = sum - (AW+1)'(BUFFER_BYTES);
    end
    wrap_add = sum[AW-1:0];
  endfunction

  function automatic logic [3:0] clamp_len(input logic [3:0] v);
    if (v == 4'd0) begin
      clamp_len = 4'd1;
    end else if (v > 4'(MAX_MARKER_BYTES)) begin
      clamp_len = 4'(MAX_MARKER_BYTES);
    end else begin
      clamp_len = v;
    end
  endfunction

  // Configuration registers.
  logic [63:0] start_marker_r, stop_marker_r;
  logic [3:0]  start_len_r, stop_len_r;

  // Buffer state.
  logic [7:0]    mem [BUFFER_BYTES];
  logic [7:0]    rdata_r;
  logic [AW-1:0] rp_r;
  logic [CW-1:0] unread_r;
  logic          dropping_r;

  // Sequencer state.
  state_t        state_r;
  logic [CW-1:0] j_r;
  logic          sfound_r, tfound_r;
  logic [CW-1:0] spos_r, tpos_r;
  logic [9:0]    len_r;
  logic [9:0]    fi_r;
  logic [3:0]    wcnt_r;
  logic [63:0]   word_r;
  logic [9:0]    maxlen_r;

  logic               out_valid_r;
  dfe_pkg::out_item_t out_r;

  logic [3:0]    sl, tl;
  logic          out_free;
  logic          in_acc;
  logic          rd_en;
  logic [AW-1:0] rd_addr;
  logic          wr_en;
  logic [AW-1:0] wr_addr;
  logic [CW-1:0] fr_off;
  dfe_pkg::match_t hits;

  assign sl       = clamp_len(start_len_r);
  assign tl       = clamp_len(stop_len_r);
  assign out_free = !out_valid_r || out_ready;
  assign in_ready = (state_r == S_IDLE) && out_free;
  assign in_acc   = in_valid && in_ready;
  assign out_valid = out_valid_r;
  assign out_data  = out_r;

  assign fr_off  = spos_r + CW'(fi_r);
  assign wr_addr = wrap_add(rp_r, unread_r[AW-1:0]);

  // A byte is stored when it opens a chunk that fits, or continues one that
  // was not dropped, and the buffer still has room.
  logic push_drop_new, push_store;
  assign push_drop_new = in_data.first_of_chunk &&
                         ((SW'(unread_r) + SW'(in_data.chunk_length)) > SW'(BUFFER_BYTES));
  assign push_store = !push_drop_new && !(!in_data.first_of_chunk && dropping_r) &&
                      (unread_r < CW'(BUFFER_BYTES));
  assign wr_en = in_acc && (in_data.action == dfe_pkg::ACT_PUSH) && push_store;

  always_comb begin
    rd_en   = 1'b0;
    rd_addr = '0;
    if (state_r == S_SCAN_RD) begin
      rd_en   = 1'b1;
      rd_addr = wrap_add(rp_r, j_r[AW-1:0]);
    end else if (state_r == S_FR_RD) begin
      rd_en   = 1'b1;
      rd_addr = wrap_add(rp_r, fr_off[AW-1:0]);
    end
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= in_data.data_byte;
    end
    if (rd_en) begin
      rdata_r <= mem[rd_addr];
    end
  end

  dfe_window_match u_match (
    .clk          (clk),
    .clear        (in_acc),
    .shift_en     (state_r == S_SCAN_CMP),
    .byte_in      (rdata_r),
    .start_marker (start_marker_r),
    .start_len    (sl),
    .stop_marker  (stop_marker_r),
    .stop_len     (tl),
    .hits         (hits)
  );

  // Scan bookkeeping for the byte now leaving the memory.
  logic [CW:0]   j_plus1;
  logic          s_new, t_new, scan_done;
  logic [CW:0]   tend;
  logic [CW:0]   full_len;
  logic [9:0]    cap_len, frame_len;
  logic [CW-1:0] adv_n;
  logic          out_load;

  assign j_plus1   = {1'b0, j_r} + 1'b1;
  assign s_new     = !sfound_r && hits.start_hit && (j_plus1 >= (CW+1)'(sl));
  assign t_new     = !tfound_r && hits.stop_hit  && (j_plus1 >= (CW+1)'(tl));
  assign scan_done = ((sfound_r || s_new) && (tfound_r || t_new)) ||
                     (j_plus1 == {1'b0, unread_r});

  assign tend     = {1'b0, tpos_r} + (CW+1)'(tl);
  assign full_len = tend - {1'b0, spos_r};
  assign cap_len  = (maxlen_r > 10'(MAX_FRAME_BYTES)) ? 10'(MAX_FRAME_BYTES) : maxlen_r;
  assign frame_len = (full_len > (CW+1)'(cap_len)) ? cap_len : full_len[9:0];
  assign adv_n    = spos_r + CW'(len_r);

  // High in every cycle in which the sequencer loads a new result.
  assign out_load =
    (in_acc && ((in_data.action == dfe_pkg::ACT_PUSH) ||
                (unread_r <= CW'(sl)) || (unread_r <= CW'(tl)))) ||
    ((state_r == S_DECIDE) && out_free &&
     !(sfound_r && tfound_r && (tend > {1'b0, spos_r}) && (frame_len != 10'd0))) ||
    ((state_r == S_EMIT) && out_free);

  function automatic dfe_pkg::out_item_t single(input logic [2:0] sts);
    single = '{status: sts, frame_word: 64'd0, word_bytes: 4'd0,
               frame_length: 10'd0, last: 1'b1};
  endfunction

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r        <= S_IDLE;
      out_valid_r    <= 1'b0;
      rp_r           <= '0;
      unread_r       <= '0;
      dropping_r     <= 1'b0;
      start_marker_r <= '0;
      stop_marker_r  <= '0;
      start_len_r    <= 4'd1;
      stop_len_r     <= 4'd1;
    end else begin
      if (cfg_we) begin
        unique case (cfg_index)
          dfe_pkg::REG_START_MARKER:     start_marker_r <= cfg_wdata;
          dfe_pkg::REG_START_MARKER_LEN: start_len_r    <= cfg_wdata[3:0];
          dfe_pkg::REG_STOP_MARKER:      stop_marker_r  <= cfg_wdata;
          dfe_pkg::REG_STOP_MARKER_LEN:  stop_len_r     <= cfg_wdata[3:0];
          default: ;
        endcase
      end

      if (out_valid_r && out_ready && !out_load) begin
        out_valid_r <= 1'b0;
      end

      unique case (state_r)
        S_IDLE: begin
          if (in_acc) begin
            if (in_data.action == dfe_pkg::ACT_PUSH) begin
              out_valid_r <= 1'b1;
              if (in_data.first_of_chunk) begin
                dropping_r <= push_drop_new;
              end
              if (push_drop_new) begin
                rp_r     <= '0;
                unread_r <= '0;
                out_r    <= single(dfe_pkg::STS_DROPPED);
              end else if (push_store) begin
                unread_r <= unread_r + 1'b1;
                out_r    <= single(dfe_pkg::STS_STORED);
              end else begin
                out_r    <= single(dfe_pkg::STS_DROPPED);
              end
            end else if ((unread_r <= CW'(sl)) || (unread_r <= CW'(tl))) begin
              out_valid_r <= 1'b1;
              out_r       <= single(dfe_pkg::STS_NOFRAME);
            end else begin
              j_r      <= '0;
              sfound_r <= 1'b0;
              tfound_r <= 1'b0;
              maxlen_r <= in_data.max_length;
              state_r  <= S_SCAN_RD;
            end
          end
        end
        S_SCAN_RD: begin
          state_r <= S_SCAN_CMP;
        end
        S_SCAN_CMP: begin
          if (s_new) begin
            sfound_r <= 1'b1;
            spos_r   <= CW'(j_plus1 - (CW+1)'(sl));
          end
          if (t_new) begin
            tfound_r <= 1'b1;
            tpos_r   <= CW'(j_plus1 - (CW+1)'(tl));
          end
          j_r     <= j_plus1[CW-1:0];
          state_r <= scan_done ? S_DECIDE : S_SCAN_RD;
        end
        S_DECIDE: begin
          if (out_free) begin
            if (!sfound_r || !tfound_r) begin
              out_valid_r <= 1'b1;
              out_r       <= single(dfe_pkg::STS_NOFRAME);
              state_r     <= S_IDLE;
            end else if (tend <= {1'b0, spos_r}) begin
              rp_r        <= wrap_add(rp_r, spos_r[AW-1:0]);
              unread_r    <= unread_r - spos_r;
              out_valid_r <= 1'b1;
              out_r       <= single(dfe_pkg::STS_JUNK);
              state_r     <= S_IDLE;
            end else if (frame_len == 10'd0) begin
              rp_r        <= wrap_add(rp_r, spos_r[AW-1:0]);
              unread_r    <= unread_r - spos_r;
              out_valid_r <= 1'b1;
              out_r       <= single(dfe_pkg::STS_FRAME);
              state_r     <= S_IDLE;
            end else begin
              len_r   <= frame_len;
              fi_r    <= '0;
              wcnt_r  <= '0;
              word_r  <= '0;
              state_r <= S_FR_RD;
            end
          end
        end
        S_FR_RD: begin
          state_r <= S_FR_CMP;
        end
        S_FR_CMP: begin
          word_r  <= word_r | (64'(rdata_r) << {wcnt_r[2:0], 3'b000});
          wcnt_r  <= wcnt_r + 1'b1;
          fi_r    <= fi_r + 1'b1;
          state_r <= ((wcnt_r == 4'd7) || (fi_r + 1'b1 == len_r)) ? S_EMIT : S_FR_RD;
        end
        S_EMIT: begin
          if (out_free) begin
            out_valid_r <= 1'b1;
            out_r <= '{status: dfe_pkg::STS_FRAME, frame_word: word_r,
                       word_bytes: wcnt_r, frame_length: len_r,
                       last: (fi_r == len_r)};
            word_r <= '0;
            wcnt_r <= '0;
            if (fi_r == len_r) begin
              rp_r     <= wrap_add(rp_r, adv_n[AW-1:0]);
              unread_r <= unread_r - adv_n;
              state_r  <= S_IDLE;
            end else begin
              state_r <= S_FR_RD;
            end
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

endmodule

// File: sv/dfe_window_match.sv
// ----------------------------------------------------------------------------
// Marker window compare
// Holds the last eight scanned bytes and compares both markers against them.
// ----------------------------------------------------------------------------
module dfe_window_match (
  input  logic            clk,
  input  logic            clear,
  input  logic            shift_en,
  input  logic [7:0]      byte_in,
  input  logic [63:0]     start_marker,
  input  logic [3:0]      start_len,
  input  logic [63:0]     stop_marker,
  input  logic [3:0]      stop_len,
  output dfe_pkg::match_t hits
);

  logic [63:0] win_r;
  logic [63:0] win_nxt;
  logic [63:0] start_tail;
  logic [63:0] stop_tail;

  // Newest byte enters at the top, so the last len bytes sit in the top lanes.
  assign win_nxt    = {byte_in, win_r[63:8]};
  assign start_tail = win_nxt >> (7'd64 - {start_len, 3'b000});
  assign stop_tail  = win_nxt >> (7'd64 - {stop_len, 3'b000});

  assign hits.start_hit = (start_tail & dfe_pkg::byte_mask(start_len)) ==
                          (start_marker & dfe_pkg::byte_mask(start_len));
  assign hits.stop_hit  = (stop_tail & dfe_pkg::byte_mask(stop_len)) ==
                          (stop_marker & dfe_pkg::byte_mask(stop_len));

  always_ff @(posedge clk) begin
    if (clear) begin
      win_r <= '0;
    end else if (shift_en) begin
      win_r <= win_nxt;
    end
  end

endmodule

// File: sv/dfe_checker.sv
// ----------------------------------------------------------------------------
// Delimited frame extractor checker
// Port-level properties of the frame extractor, bound to the top level.
// ----------------------------------------------------------------------------
module dfe_checker (
  input logic               clk,
  input logic               rst_n,
  input logic               in_valid,
  input logic               in_ready,
  input dfe_pkg::in_item_t  in_data,
  input logic               out_valid,
  input logic               out_ready,
  input dfe_pkg::out_item_t out_data
);

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_data))
    else $error("result changed while stalled");

  a_push_result: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready && (in_data.action == dfe_pkg::ACT_PUSH) |=>
      out_valid && out_data.last &&
      (out_data.status == dfe_pkg::STS_STORED || out_data.status == dfe_pkg::STS_DROPPED))
    else $error("push did not give a single stored or dropped result");

  a_single_shape: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_data.status != dfe_pkg::STS_FRAME) |->
      out_data.last && (out_data.word_bytes == 4'd0) && (out_data.frame_word == 64'd0))
    else $error("non-frame result not a lone empty result");

  a_word_fill: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_data.status == dfe_pkg::STS_FRAME) && !out_data.last |->
      out_data.word_bytes == 4'd8)
    else $error("partial word before end of frame");

endmodule

bind delimited_frame_extractor dfe_checker u_dfe_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_valid  (in_valid),
  .in_ready  (in_ready),
  .in_data   (in_data),
  .out_valid (out_valid),
  .out_ready (out_ready),
  .out_data  (out_data)
);

// File: dv/delimited_frame_extractor_tb.sv
// ----------------------------------------------------------------------------
// Delimited frame extractor testbench
// Drives pushed bytes and extract requests with bursty traffic and a stalling
// receiver, predicts every result transaction and checks them in order.
// ----------------------------------------------------------------------------
module delimited_frame_extractor_tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int STORE_BYTES = dfe_pkg::DEF_BUFFER_BYTES;
  localparam int IDLE_LIMIT  = 60000;

  // The scoreboard keeps its own copy of the ring buffer, the read point, the
  // unread count, the drop flag and the marker registers. Each accepted input
  // transaction is turned into its result transactions here, and results
  // coming out of the block are checked in order against them.
  class frame_scoreboard;
    logic [7:0]  ring[STORE_BYTES];
    int          rd_ptr;
    int          unread;
    bit          dropping;
    logic [63:0] start_pat;
    logic [3:0]  start_len_reg;
    logic [63:0] stop_pat;
    logic [3:0]  stop_len_reg;
    dfe_pkg::out_item_t pending[$];
    int          errors;
    int          checked;
    int          frames;
    int          junk_skips;
    int          drops;

    function new();
      rd_ptr        = 0;
      unread        = 0;
      dropping      = 0;
      start_pat     = '0;
      start_len_reg = 4'd1;
      stop_pat      = '0;
      stop_len_reg  = 4'd1;
      errors        = 0;
      checked       = 0;
      frames        = 0;
      junk_skips    = 0;
      drops         = 0;
    endfunction

    function void write_reg(logic [1:0] idx, logic [63:0] val);
      case (idx)
        dfe_pkg::REG_START_MARKER:     start_pat     = val;
        dfe_pkg::REG_START_MARKER_LEN: start_len_reg = val[3:0];
        dfe_pkg::REG_STOP_MARKER:      stop_pat      = val;
        dfe_pkg::REG_STOP_MARKER_LEN:  stop_len_reg  = val[3:0];
        default: ;
      endcase
    endfunction

    // Out-of-range marker lengths are pulled back into 1..8.
    function int clamp_len(logic [3:0] v);
      if (v == 0) return 1;
      if (v > dfe_pkg::DEF_MAX_MARKER_BYTES) return dfe_pkg::DEF_MAX_MARKER_BYTES;
      return v;
    endfunction

    function logic [7:0] peek(int off);
      return ring[(rd_ptr + off) % STORE_BYTES];
    endfunction

    function bit find_marker(logic [63:0] pat, int len, output int pos);
      bit hit;
      pos = 0;
      for (int i = 0; i + len <= unread; i++) begin
        hit = 1;
        for (int k = 0; k < len && hit; k++)
          if (peek(i + k) != pat[8*k +: 8]) hit = 0;
        if (hit) begin
          pos = i;
          return 1;
        end
      end
      return 0;
    endfunction

    function void add_result(logic [2:0] st, logic [63:0] word, int nbytes, int flen,
                             bit fin);
      dfe_pkg::out_item_t r;
      r.status       = st;
      r.frame_word   = word;
      r.word_bytes   = nbytes[3:0];
      r.frame_length = flen[9:0];
      r.last         = fin;
      pending.push_back(r);
    endfunction

    function void move_read_point(int n);
      rd_ptr = (rd_ptr + n) % STORE_BYTES;
      unread -= n;
    endfunction

    function void note_input(dfe_pkg::in_item_t it);
      int sl, tl, spos, tpos, tend, len, maxlen, cnt;
      logic [63:0] word;
      if (it.action == dfe_pkg::ACT_PUSH) begin
        if (it.first_of_chunk) begin
          dropping = (unread + it.chunk_length) > STORE_BYTES;
          if (dropping) begin
            rd_ptr = 0;
            unread = 0;
            drops++;
            add_result(dfe_pkg::STS_DROPPED, '0, 0, 0, 1);
            return;
          end
        end else if (dropping) begin
          add_result(dfe_pkg::STS_DROPPED, '0, 0, 0, 1);
          return;
        end
        // A chunk whose length was understated can overrun a full buffer.
        if (unread >= STORE_BYTES) begin
          add_result(dfe_pkg::STS_DROPPED, '0, 0, 0, 1);
          return;
        end
        ring[(rd_ptr + unread) % STORE_BYTES] = it.data_byte;
        unread++;
        add_result(dfe_pkg::STS_STORED, '0, 0, 0, 1);
        return;
      end
      sl = clamp_len(start_len_reg);
      tl = clamp_len(stop_len_reg);
      if (unread <= sl || unread <= tl || !find_marker(start_pat, sl, spos) ||
          !find_marker(stop_pat, tl, tpos)) begin
        add_result(dfe_pkg::STS_NOFRAME, '0, 0, 0, 1);
        return;
      end
      tend = tpos + tl;
      if (tend <= spos) begin
        move_read_point(spos);
        junk_skips++;
        add_result(dfe_pkg::STS_JUNK, '0, 0, 0, 1);
        return;
      end
      maxlen = it.max_length;
      if (maxlen > dfe_pkg::DEF_MAX_FRAME_BYTES) maxlen = dfe_pkg::DEF_MAX_FRAME_BYTES;
      len = tend - spos;
      if (len > maxlen) len = maxlen;
      frames++;
      if (len == 0) begin
        move_read_point(spos);
        add_result(dfe_pkg::STS_FRAME, '0, 0, 0, 1);
        return;
      end
      for (int i = 0; i < len; i += 8) begin
        cnt  = (len - i < 8) ? len - i : 8;
        word = '0;
        for (int k = 0; k < cnt; k++) word[8*k +: 8] = peek(spos + i + k);
        add_result(dfe_pkg::STS_FRAME, word, cnt, len, (i + cnt >= len));
      end
      move_read_point(spos + len);
    endfunction

    task report(string what, logic [63:0] got, logic [63:0] want);
      $display("[%0t] result %0d: %s got 0x%0h, wanted 0x%0h", $realtime, checked,
               what, got, want);
      errors++;
    endtask

    task check_result(dfe_pkg::out_item_t got);
      dfe_pkg::out_item_t want;
      if (pending.size() == 0) begin
        report("unexpected result, status", got.status, 0);
        return;
      end
      want = pending.pop_front();
      if (got.status !== want.status) report("status", got.status, want.status);
      if (got.frame_word !== want.frame_word)
        report("frame_word", got.frame_word, want.frame_word);
      if (got.word_bytes !== want.word_bytes)
        report("word_bytes", got.word_bytes, want.word_bytes);
      if (got.frame_length !== want.frame_length)
        report("frame_length", got.frame_length, want.frame_length);
      if (got.last !== want.last) report("last", got.last, want.last);
      checked++;
    endtask
  endclass

  logic               clk = 1'b0;
  logic               rst_n = 1'b0;
  logic               in_valid = 1'b0;
  logic               in_ready;
  dfe_pkg::in_item_t  in_data = '0;
  logic               out_valid;
  logic               out_ready = 1'b0;
  dfe_pkg::out_item_t out_data;
  logic               cfg_we = 1'b0;
  logic [1:0]         cfg_index = dfe_pkg::REG_START_MARKER;
  logic [63:0]        cfg_wdata = '0;

  frame_scoreboard sb = new();

  int burst_left = 0;
  int items_sent = 0;
  int idle_cycles = 0;
  int cycle_count = 0;

  delimited_frame_extractor DUT (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  // The receiver cycles through three moods: always ready, random stalls,
  // and a fixed stall pattern, so that back-pressure lands on every phase of
  // an extract as well as on the push results.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    case ((cycle_count / 700) % 3)
      0:       out_ready <= 1'b1;
      1:       out_ready <= ($urandom_range(0, 2) != 0);
      default: out_ready <= (cycle_count % 7 != 3) && (cycle_count % 7 != 4);
    endcase
  end

  // Results are sampled at the edge, before anything driven there settles.
  always @(posedge clk) begin
    if (rst_n && out_valid && out_ready) sb.check_result(out_data);
  end

  // The watchdog only counts cycles in which neither channel moves a
  // transaction; a long extract on a full buffer stays well inside the limit.
  always @(posedge clk) begin
    if ((in_valid && in_ready) || (out_valid && out_ready)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
    if (idle_cycles >= IDLE_LIMIT) begin
      $display("Watchdog expired after %0d quiet cycles", idle_cycles);
      $display("SCOREBOARD MISMATCH");
      $finish;
    end
  end

  // One input transaction. The sender works in bursts; between bursts it
  // may drop valid for a random number of cycles. Valid stays high with the
  // payload unchanged until the block takes the transaction.
  task automatic send(input dfe_pkg::in_item_t it);
    int gap;
    if (burst_left == 0) begin
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
      if (gap > 0) begin
        in_valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      burst_left = $urandom_range(1, 40);
    end
    burst_left--;
    in_valid <= 1'b1;
    in_data  <= it;
    do @(posedge clk); while (!(in_valid && in_ready));
    sb.note_input(it);
    items_sent++;
  endtask

  task automatic push(input logic [7:0] b, input bit first, input int chunk);
    dfe_pkg::in_item_t it;
    it.action         = dfe_pkg::ACT_PUSH;
    it.data_byte      = b;
    it.first_of_chunk = first;
    it.chunk_length   = chunk[12:0];
    it.max_length     = 10'($urandom_range(0, 1023));
    send(it);
  endtask

  task automatic extract(input int maxlen);
    dfe_pkg::in_item_t it;
    it.action         = dfe_pkg::ACT_EXTRACT;
    it.data_byte      = 8'($urandom_range(0, 255));
    it.first_of_chunk = 1'($urandom_range(0, 1));
    it.chunk_length   = 13'($urandom_range(0, 8191));
    it.max_length     = maxlen[9:0];
    send(it);
  endtask

  // Pause the sender until every expected result has arrived, then let the
  // block settle before anything is reconfigured.
  task automatic drain();
    in_valid <= 1'b0;
    burst_left = 0;
    do @(posedge clk); while (sb.pending.size() != 0);
    repeat (8) @(posedge clk);
  endtask

  task automatic cfg_write(input logic [1:0] idx, input logic [63:0] val);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= val;
    @(posedge clk);
    sb.write_reg(idx, val);
  endtask

  task automatic set_markers(input logic [63:0] sp, input logic [3:0] sl,
                             input logic [63:0] tp, input logic [3:0] tl);
    cfg_write(dfe_pkg::REG_START_MARKER, sp);
    cfg_write(dfe_pkg::REG_START_MARKER_LEN, {60'd0, sl});
    cfg_write(dfe_pkg::REG_STOP_MARKER, tp);
    cfg_write(dfe_pkg::REG_STOP_MARKER_LEN, {60'd0, tl});
    cfg_we <= 1'b0;
    @(posedge clk);
  endtask

  // A well-formed chunk: some junk, the start marker, a payload, the stop
  // marker and a little trailing junk, followed by an extract. Now and then
  // the declared chunk length is wrong or the extract is cut short.
  task automatic frame_sequence();
    logic [7:0] bytes[$];
    int sl, tl, declared, maxlen;
    sl = sb.clamp_len(sb.start_len_reg);
    tl = sb.clamp_len(sb.stop_len_reg);
    repeat ($urandom_range(0, 6)) bytes.push_back(8'($urandom_range(0, 255)));
    for (int k = 0; k < sl; k++) bytes.push_back(sb.start_pat[8*k +: 8]);
    repeat ($urandom_range(0, 20)) bytes.push_back(8'($urandom_range(0, 255)));
    for (int k = 0; k < tl; k++) bytes.push_back(sb.stop_pat[8*k +: 8]);
    repeat ($urandom_range(0, 3)) bytes.push_back(8'($urandom_range(0, 255)));
    declared = ($urandom_range(0, 7) == 0) ? $urandom_range(0, bytes.size() + 5)
                                          : bytes.size();
    foreach (bytes[i]) push(bytes[i], i == 0, declared);
    case ($urandom_range(0, 9))
      0:       maxlen = 0;
      1:       maxlen = $urandom_range(1, 7);
      2:       maxlen = $urandom_range(513, 1023);
      default: maxlen = $urandom_range(8, 512);
    endcase
    extract(maxlen);
  endtask

  // Anything at all: random fields, with chunk lengths mostly modest so the
  // buffer is not emptied all the time.
  task automatic noise_item();
    dfe_pkg::in_item_t it;
    it.action         = 1'($urandom_range(0, 1));
    it.data_byte      = 8'($urandom_range(0, 255));
    it.first_of_chunk = 1'($urandom_range(0, 1));
    it.chunk_length   = ($urandom_range(0, 19) == 0) ? 13'($urandom_range(0, 8191))
                                                     : 13'($urandom_range(0, 64));
    it.max_length     = 10'($urandom_range(0, 1023));
    send(it);
  endtask

  task automatic random_phase(input int count);
    int target;
    target = items_sent + count;
    while (items_sent < target) begin
      if ($urandom_range(0, 9) < 7) frame_sequence();
      else noise_item();
    end
  endtask

  initial begin
    logic [63:0] rp, rt;
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed part with one-byte markers.
    set_markers(64'h3C, 4'd1, 64'h3E, 4'd1);
    extract(100);                       // nothing buffered: no frame
    push(8'h11, 1, 6);
    push(8'h3C, 0, 6);
    push(8'hAA, 0, 6);
    push(8'h3E, 0, 6);
    push(8'h00, 0, 6);
    push(8'hFF, 0, 6);
    extract(0);                         // zero length: read point to the start
    extract(1023);                      // over-long limit, short frame
    extract(512);                       // markers gone: no frame
    push(8'h3E, 1, 3);
    push(8'h3C, 0, 3);
    push(8'h77, 0, 3);
    extract(512);                       // stop before start: junk skipped
    extract(512);                       // stop marker missing
    push(8'h01, 1, 8191);               // chunk too big: buffer emptied
    push(8'h02, 0, 8191);               // rest of the dropped chunk
    push(8'h80, 1, 4096);               // exactly fits: stored
    push(8'h3C, 0, 4096);
    push(8'h3E, 0, 4096);
    extract(1);
    drain();

    // Long markers over the whole byte range.
    set_markers(64'hFFFF_FFFF_FFFF_FFFF, 4'd8, 64'h0, 4'd8);
    random_phase(50);
    drain();

    // Out-of-range lengths: zero acts as one, fifteen as eight.
    set_markers({$urandom, $urandom}, 4'd0, {$urandom, $urandom}, 4'd15);
    random_phase(50);
    drain();

    for (int p = 0; p < 4; p++) begin
      rp = {$urandom, $urandom};
      rt = {$urandom, $urandom};
      set_markers(rp, 4'($urandom_range(0, 15)), rt, 4'($urandom_range(0, 15)));
      random_phase(45);
      drain();
    end

    set_markers(64'h0, 4'd1, 64'h0, 4'd1);
    random_phase(30);
    drain();

    $display("Covered %0d input transactions, %0d results: %0d frames, %0d junk skips,",
             items_sent, sb.checked, sb.frames, sb.junk_skips);
    $display("%0d chunk drops, over several marker settings and stall patterns.",
             sb.drops);
    if (sb.errors == 0 && sb.pending.size() == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("%0d mismatches, %0d results outstanding", sb.errors, sb.pending.size());
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule
